>>> rtl/csvt_pkg.sv
// Shared types and character codes for the CSV byte tokenizer.
`default_nettype none

package csvt_pkg;

   // Character codes
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   // Parser state codes
   localparam logic [2:0] ST_ROW_START   = 3'd0;
   localparam logic [2:0] ST_FIELD_START = 3'd1;
   localparam logic [2:0] ST_UNQUOTED    = 3'd2;
   localparam logic [2:0] ST_QUOTED      = 3'd3;
   localparam logic [2:0] ST_AFTER_QUOTE = 3'd4;

   // Error codes
   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_QUOTE_IN_RAW = 2'd1;
   localparam logic [1:0] ERR_EOF_IN_QUOTE = 2'd2;
   localparam logic [1:0] ERR_AFTER_QUOTE  = 2'd3;

   typedef struct packed {
      logic [2:0] parse_state;
      logic       swallow_linefeed;
      logic [1:0] sticky_error;
   } csvt_state_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_out;
      logic       field_end;
      logic       row_end;
      logic       stream_end;
      logic [1:0] error_code;
   } csvt_result_type;

endpackage

`default_nettype wire

>>> rtl/csv_byte_tokenizer_top.sv
// Top level of the CSV byte tokenizer: input stage, parser state, result register.
// Each word taken on req_ passes through the input register and then the result register
//    before it is presented on rsp_; one result word per input word.
// Throughput: one word per cycle while rsp_ready stays high; the parser step is combinational
//    between the input and result registers; a stalled rsp_ backs up into req_ready once both stages are full.
// Reset (synchronous, active high): empty both stages, return to row start, clear flags.
`default_nettype none

module csv_byte_tokenizer_top
   import csvt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_char_valid,
   output logic [7:0]       rsp_char_out,
   output logic             rsp_field_end,
   output logic             rsp_row_end,
   output logic             rsp_stream_end,
   output logic [1:0]       rsp_error_code
);

   // Input stage
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_eoi_ff;

   // Parser state
   csvt_state_type  state_ff, state_in;

   // Result stage
   logic            out_valid_ff, out_valid_in;
   csvt_result_type out_ff;

   csvt_state_type  step_state;
   csvt_result_type step_result;
   logic            advance;
   logic            req_take;

   // Advance the input word into the result register when the result slot is
   // empty or being drained this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   csvt_step u_step (
      .data_byte    (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .cur_state    (state_ff),
      .nxt_state    (step_state),
      .result       (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      state_in     = state_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         // commit the parser step only when its result is latched
         out_valid_in = 1'b1;
         state_in     = step_state;
         in_valid_in  = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{parse_state: ST_ROW_START, swallow_linefeed: 1'b0,
                           sticky_error: ERR_NONE};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers: input loads on handshake, result loads on advance, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_eoi_ff  <= req_end_of_input;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_char_valid = out_ff.char_valid;
   assign rsp_char_out   = out_ff.char_out;
   assign rsp_field_end  = out_ff.field_end;
   assign rsp_row_end    = out_ff.row_end;
   assign rsp_stream_end = out_ff.stream_end;
   assign rsp_error_code = out_ff.error_code;

`ifndef SYNTHESIS
   // A sticky error never changes until reset
   a_sticky_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff.sticky_error != ERR_NONE) |=> $stable(state_ff.sticky_error))
      else $error("sticky error changed");

   // An error word carries nothing else
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.error_code != ERR_NONE)) |->
      (!out_ff.char_valid && !out_ff.field_end && !out_ff.row_end && !out_ff.stream_end))
      else $error("error word carries other marks");

   // A row end always closes a field
   a_row_closes_field: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.row_end) |-> out_ff.field_end)
      else $error("row end without field end");

   // A data byte never comes with a field end
   a_char_not_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.char_valid) |-> !out_ff.field_end)
      else $error("data byte with field end");

   // A pending LF swallow only exists right after a row ended
   a_swallow_at_row_start: assert property (@(posedge clock) disable iff (reset)
      state_ff.swallow_linefeed |-> (state_ff.parse_state == ST_ROW_START))
      else $error("swallow flag outside row start");
`endif

endmodule

`default_nettype wire

>>> rtl/csvt_step.sv
// Next-state and result logic for one word of the CSV tokenizer.
`default_nettype none

module csvt_step
   import csvt_pkg::*;
(
   input  wire logic [7:0]      data_byte,
   input  wire logic            end_of_input,
   input  wire csvt_state_type  cur_state,
   output csvt_state_type       nxt_state,
   output csvt_result_type      result
);

   logic is_eor;
   logic is_quote;
   logic is_comma;

   assign is_eor   = end_of_input || (data_byte == CH_LF) || (data_byte == CH_CR);
   assign is_quote = !end_of_input && (data_byte == CH_QUOTE);
   assign is_comma = !end_of_input && (data_byte == CH_COMMA);

   always_comb begin
      logic end_row;
      end_row   = 1'b0;
      nxt_state = cur_state;
      result    = '0;

      if (cur_state.sticky_error != ERR_NONE) begin
         // hold the first error forever
         result.error_code = cur_state.sticky_error;
      end else begin
         nxt_state.swallow_linefeed = 1'b0;
         if (cur_state.swallow_linefeed && !end_of_input && (data_byte == CH_LF)) begin
            // drop the LF of a CR-LF pair
         end else begin
            unique case (cur_state.parse_state)
               ST_UNQUOTED: begin
                  if (is_eor) begin
                     end_row = 1'b1;
                  end else if (is_comma) begin
                     result.field_end      = 1'b1;
                     nxt_state.parse_state = ST_FIELD_START;
                  end else if (is_quote) begin
                     nxt_state.sticky_error = ERR_QUOTE_IN_RAW;
                     result.error_code      = ERR_QUOTE_IN_RAW;
                  end else begin
                     result.char_valid = 1'b1;
                     result.char_out   = data_byte;
                  end
               end
               ST_QUOTED: begin
                  if (end_of_input) begin
                     nxt_state.sticky_error = ERR_EOF_IN_QUOTE;
                     result.error_code      = ERR_EOF_IN_QUOTE;
                  end else if (is_quote) begin
                     nxt_state.parse_state = ST_AFTER_QUOTE;
                  end else begin
                     result.char_valid = 1'b1;
                     result.char_out   = data_byte;
                  end
               end
               ST_AFTER_QUOTE: begin
                  if (is_eor) begin
                     end_row = 1'b1;
                  end else if (is_quote) begin
                     result.char_valid     = 1'b1;
                     result.char_out       = CH_QUOTE;
                     nxt_state.parse_state = ST_QUOTED;
                  end else if (is_comma) begin
                     result.field_end      = 1'b1;
                     nxt_state.parse_state = ST_FIELD_START;
                  end else begin
                     nxt_state.sticky_error = ERR_AFTER_QUOTE;
                     result.error_code      = ERR_AFTER_QUOTE;
                  end
               end
               default: begin
                  // row start, field start, and unused codes
                  if ((cur_state.parse_state != ST_FIELD_START) && end_of_input) begin
                     result.stream_end     = 1'b1;
                     nxt_state.parse_state = ST_ROW_START;
                  end else if (is_quote) begin
                     nxt_state.parse_state = ST_QUOTED;
                  end else if (is_eor) begin
                     end_row = 1'b1;
                  end else if (is_comma) begin
                     result.field_end      = 1'b1;
                     nxt_state.parse_state = ST_FIELD_START;
                  end else begin
                     result.char_valid     = 1'b1;
                     result.char_out       = data_byte;
                     nxt_state.parse_state = ST_UNQUOTED;
                  end
               end
            endcase

            if (end_row) begin
               result.field_end           = 1'b1;
               result.row_end             = 1'b1;
               result.stream_end          = end_of_input;
               nxt_state.swallow_linefeed = !end_of_input && (data_byte == CH_CR);
               nxt_state.parse_state      = ST_ROW_START;
            end
         end
      end
   end

endmodule

`default_nettype wire
